// ===== hw/rtl/cstb_pkg.sv =====
// Shared types and constants for the child supervision timer bank.
// Holds request codes, the controller state encoding and the command/status
// structs that join the controller to the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cstb_pkg;

  localparam int unsigned IntervalW = 16;
  localparam int unsigned ChildW    = 4;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_SENT  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick_start;
    logic step;
    logic wr_entry;
    logic clr_cnt;
    logic emit_load;
  } cstb_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic walk_done;
    logic emit_last;
    logic slot_free;
  } cstb_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/child_supervision_timer_bank.sv =====
// Top level of the child supervision timer bank.
// Unpacks the stream fields and joins cstb_ctrl to cstb_dp.
// Depends on cstb_pkg, cstb_ctrl and cstb_dp.
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid / tready        tuser: req_type; tdata: request fields
//  m_axis    out        tvalid / tready        tuser: send_supervision; tdata: child; tlast
//  cfg       in         cfg_valid / cfg_ready  cfg_data: supervisor_enable
//
// A write, sent, unknown or disabled-tick request is accepted, then loads its single
// result. An enabled tick is accepted, walks min(MAX_CHILDREN, 16) entries through
// one shared increment and compare, then loads each result once the output is free.
// Reset is immediate: the entry valid bits clear, no memory pass.
// The output register holds the last result while the next request is accepted;
// a stalled output holds up the next result load, and the input waits until it is done.
`timescale 1ns / 1ps
`default_nettype none

module child_supervision_timer_bank
  import cstb_pkg::*;
#(
  parameter int unsigned MAX_CHILDREN = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [3:0] child_index, [4] entry_valid, [5] entry_rx_on_idle,
  // [21:6] entry_interval, [37:22] pending_mask, [39:38] zero
  input  wire logic [39:0] s_axis_tdata_i,
  // [1:0] req_type
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [3:0] child_index_res, [7:4] zero
  output logic [7:0]       m_axis_tdata_o,
  // [0] send_supervision
  output logic [0:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_data_i
);

  cstb_cmd_t         cmd;
  cstb_status_t      st;
  logic [ChildW-1:0] child_res;
  logic              send;

  cstb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .req_type_i   (req_type_e'(s_axis_tuser_i)),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_enable_i (cfg_data_i[0]),
    .st_i         (st),
    .cmd_o        (cmd)
  );

  cstb_dp #(
    .MAX_CHILDREN (MAX_CHILDREN)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .st_o               (st),
    .child_index_i      (s_axis_tdata_i[3:0]),
    .entry_valid_i      (s_axis_tdata_i[4]),
    .entry_rx_on_idle_i (s_axis_tdata_i[5]),
    .entry_interval_i   (s_axis_tdata_i[21:6]),
    .pending_mask_i     (s_axis_tdata_i[37:22]),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .child_index_res_o  (child_res),
    .send_supervision_o (send),
    .last_o             (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, child_res};
  assign m_axis_tuser_o = send;

endmodule

`default_nettype wire

// ===== hw/rtl/cstb_ctrl.sv =====
// Controller state machine of the child supervision timer bank.
// Decodes requests, sequences the entry walk and the result emission.
// Depends on cstb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cstb_ctrl
  import cstb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire req_type_e    req_type_i,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_enable_i,
  input  wire cstb_status_t st_i,
  output cstb_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        en_q;
  logic        accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      en_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        en_q <= cfg_enable_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EMIT;
          case (req_type_i)
            REQ_TICK: begin
              if (en_q) begin
                cmd_o.tick_start = 1'b1;
                state_d          = ST_WALK;
              end
            end
            REQ_WRITE: cmd_o.wr_entry = 1'b1;
            REQ_SENT:  cmd_o.clr_cnt  = 1'b1;
            default:   ;
          endcase
        end
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (st_i.walk_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st_i.slot_free) begin
          cmd_o.emit_load = 1'b1;
          if (st_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_non_tick_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i != REQ_TICK) |=> state_q == ST_EMIT)
    else $error("non-tick request did not go to emission");

  a_walk_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && !st_i.walk_done) |=> state_q == ST_WALK)
    else $error("walk left before the last entry");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cstb_dp.sv =====
// Datapath of the child supervision timer bank: entry table, seconds
// counters, walk index, hit mask and the output result register.
// Depends on cstb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cstb_dp
  import cstb_pkg::*;
#(
  parameter int unsigned MAX_CHILDREN = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cstb_cmd_t            cmd_i,
  output cstb_status_t              st_o,
  input  wire logic [ChildW-1:0]    child_index_i,
  input  wire logic                 entry_valid_i,
  input  wire logic                 entry_rx_on_idle_i,
  input  wire logic [IntervalW-1:0] entry_interval_i,
  input  wire logic [IntervalW-1:0] pending_mask_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [ChildW-1:0]         child_index_res_o,
  output logic                      send_supervision_o,
  output logic                      last_o
);

  // Only the first sixteen entries can ever be written, so only they exist.
  localparam int unsigned WalkN = (MAX_CHILDREN < 16) ? MAX_CHILDREN : 16;
  localparam int unsigned IdxW  = (WalkN > 1) ? $clog2(WalkN) : 1;

  logic [WalkN-1:0]     valid_q;
  logic [WalkN-1:0]     rx_on_q;
  logic [IntervalW-1:0] intv_q [WalkN];
  logic [IntervalW-1:0] cnt_q  [WalkN];
  logic [WalkN-1:0]     pend_q;
  logic [WalkN-1:0]     hit_q;
  logic [IdxW-1:0]      widx_q;
  logic                 out_valid_q;
  logic [ChildW-1:0]    out_child_q;
  logic                 out_send_q;
  logic                 out_last_q;

  logic                 in_range;
  logic [IdxW-1:0]      wr_idx;
  logic [IntervalW-1:0] cur_cnt;
  logic [IntervalW-1:0] cur_intv;
  logic [IntervalW-1:0] cnt_inc;
  logic                 eligible;
  logic                 hit;
  logic [WalkN-1:0]     hit_rest;
  logic [ChildW-1:0]    first_hit;
  logic                 emit_last;

  assign in_range = (32'(child_index_i) < MAX_CHILDREN);
  assign wr_idx   = IdxW'(child_index_i);

  assign cur_cnt  = cnt_q[widx_q];
  assign cur_intv = intv_q[widx_q];
  assign eligible = valid_q[widx_q] && !rx_on_q[widx_q] && (cur_intv != '0);
  assign cnt_inc  = (cur_cnt == '1) ? cur_cnt : cur_cnt + IntervalW'(1);
  assign hit      = eligible && (cnt_inc >= cur_intv) && !pend_q[widx_q];

  // Lowest pending hit goes out first; the rest decide the last flag.
  assign hit_rest  = hit_q & (hit_q - WalkN'(1));
  assign emit_last = (hit_rest == '0);

  always_comb begin
    first_hit = '0;
    for (int i = WalkN - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        first_hit = ChildW'(i);
      end
    end
  end

  assign st_o.walk_done = (widx_q == IdxW'(WalkN - 1));
  assign st_o.emit_last = emit_last;
  assign st_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rx_on_q     <= '0;
      hit_q       <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_entry && in_range) begin
        valid_q[wr_idx] <= entry_valid_i;
        rx_on_q[wr_idx] <= entry_rx_on_idle_i;
      end
      if (cmd_i.tick_start) begin
        hit_q  <= '0;
        widx_q <= '0;
      end else if (cmd_i.step) begin
        if (hit) begin
          hit_q[widx_q] <= 1'b1;
        end
        widx_q <= widx_q + IdxW'(1);
      end else if (cmd_i.emit_load) begin
        hit_q <= hit_rest;
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry && in_range) begin
      intv_q[wr_idx] <= entry_interval_i;
      cnt_q[wr_idx]  <= '0;
    end else if (cmd_i.clr_cnt && in_range) begin
      cnt_q[wr_idx] <= '0;
    end else if (cmd_i.step && eligible) begin
      cnt_q[widx_q] <= cnt_inc;
    end
    if (cmd_i.tick_start) begin
      pend_q <= pending_mask_i[WalkN-1:0];
    end
    if (cmd_i.emit_load) begin
      out_child_q <= first_hit;
      out_send_q  <= (hit_q != '0);
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign child_index_res_o  = out_child_q;
  assign send_supervision_o = out_send_q;
  assign last_o             = out_last_q;

`ifndef SYNTH
  a_mask_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_load && emit_last) |=> hit_q == '0)
    else $error("hit mask not empty after final result");

  a_idle_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_send_q) |-> (out_last_q && out_child_q == '0))
    else $error("no-request result is malformed");
`endif

endmodule

`default_nettype wire
